>>> sv/psp_pkg.sv
package psp_pkg;

    typedef enum logic [4:0] {
        S_IDLE,
        S_POP,
        T_LIST,
        T_LA,
        T_SLOT,
        T_M0,
        T_M1,
        T_M2,
        T_M3,
        T_WR,
        T_RM1,
        T_RM2,
        R_A,
        R_S,
        R_O
    } state_t;

    typedef enum logic [1:0] {
        REQ_SPAWN = 2'd0,
        REQ_TICK  = 2'd1,
        REQ_READ  = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    localparam logic signed [16:0] DAMP_Q16 = 17'sd64225;

    // Round Q.20 step to Q.8, add to position, saturate to 24 bits.
    function automatic logic signed [23:0] pos_step(input logic signed [23:0] p,
                                                    input logic signed [41:0] prod);
        logic signed [41:0] r;
        logic signed [31:0] s;
        r = (prod + 42'sd2048) >>> 12;
        s = 32'(p) + 32'(r);
        if (s > 32'sd8388607)
            pos_step = 24'h7FFFFF;
        else if (s < -32'sd8388608)
            pos_step = 24'h800000;
        else
            pos_step = 24'(s);
    endfunction

    // Q0.16 damping product, truncated toward zero.
    function automatic logic signed [23:0] damp(input logic signed [41:0] prod);
        logic signed [41:0] r;
        r = prod + (prod[41] ? 42'sd65535 : 42'sd0);
        damp = 24'(r >>> 16);
    endfunction

endpackage

>>> sv/psp_mac.sv
module psp_mac
    import psp_pkg::*;
(
    input  logic               clk,
    input  logic signed [23:0] a,
    input  logic signed [16:0] b,
    output logic signed [41:0] prod
);

    logic signed [41:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= 42'(a) * 42'(b);
    end

    assign prod = prod_reg;

endmodule

>>> sv/particle_slot_pool.sv
// Particle slot pool. Raise start while busy is low to issue a request (spawn,
// tick or read); busy stays high until the single result strobes on done for
// one cycle, which the receiver must take as it comes. A refused spawn, an
// out-of-range read or a request with an unused code is answered straight from
// idle. A tick walks the active list and does four products per entry on one
// shared multiplier; an expired entry also passes the swap-remove states.
module particle_slot_pool
    import psp_pkg::*;
#(
    parameter int SLOT_COUNT = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         req_type,
    input  logic signed [23:0] pos_x,
    input  logic signed [23:0] pos_y,
    input  logic signed [23:0] vel_x,
    input  logic signed [23:0] vel_y,
    input  logic [7:0]         dot_size,
    input  logic [31:0]        rgba,
    input  logic [15:0]        life_init,
    input  logic [15:0]        step_time,
    input  logic [5:0]         list_pos,
    output logic               done,
    output logic               ok,
    output logic [5:0]         slot_id,
    output logic [6:0]         live_count,
    output logic signed [23:0] out_pos_x,
    output logic signed [23:0] out_pos_y,
    output logic [7:0]         out_size,
    output logic [31:0]        out_rgba,
    output logic [15:0]        life_left,
    output logic [15:0]        life_total
);

    localparam int IW = $clog2(SLOT_COUNT);
    localparam int CW = $clog2(SLOT_COUNT + 1);

    state_t state_reg, state_next;

    logic [CW-1:0] free_top_reg, free_top_next;
    logic [CW-1:0] lw_reg, lw_next;
    logic [CW-1:0] total_reg, total_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [IW-1:0] slot_reg, slot_next;

    // latched request
    logic signed [23:0] px_in_reg, py_in_reg, vx_in_reg, vy_in_reg;
    logic [7:0]         size_in_reg;
    logic [31:0]        rgba_in_reg;
    logic [15:0]        life_in_reg, dt_reg;

    // tick results
    logic signed [23:0] npx_reg, npx_next, npy_reg, npy_next, nvx_reg, nvx_next;

    // result registers
    logic               done_reg, done_next;
    logic               ok_reg, ok_next;
    logic [5:0]         slot_id_reg, slot_id_next;
    logic signed [23:0] rpx_reg, rpx_next, rpy_reg, rpy_next;
    logic [7:0]         rsize_reg, rsize_next;
    logic [31:0]        rrgba_reg, rrgba_next;
    logic [15:0]        rlife_reg, rlife_next, rlmax_reg, rlmax_next;

    // memories
    logic [IW-1:0]      free_mem [SLOT_COUNT];
    logic [IW-1:0]      alist_mem [SLOT_COUNT];
    logic signed [23:0] spx_mem [SLOT_COUNT];
    logic signed [23:0] spy_mem [SLOT_COUNT];
    logic signed [23:0] svx_mem [SLOT_COUNT];
    logic signed [23:0] svy_mem [SLOT_COUNT];
    logic [15:0]        slife_mem [SLOT_COUNT];
    logic [15:0]        slmax_mem [SLOT_COUNT];
    logic [7:0]         ssize_mem [SLOT_COUNT];
    logic [31:0]        srgba_mem [SLOT_COUNT];

    logic [IW-1:0]      fs_ra, fs_q;
    logic               fs_we;
    logic [IW-1:0]      al_ra, al_q, al_wa, al_wd;
    logic               al_we;
    logic               st_we;
    logic [IW-1:0]      st_wa;
    logic signed [23:0] st_px, st_py, st_vx, st_vy;
    logic [15:0]        st_life;
    logic signed [23:0] q_px, q_py, q_vx, q_vy;
    logic [15:0]        q_life, q_lmax;
    logic [7:0]         q_size;
    logic [31:0]        q_rgba;

    logic signed [23:0] mac_a;
    logic signed [16:0] mac_b;
    logic signed [41:0] prod;
    logic [15:0]        life_dec;
    logic [IW-1:0]      pop_idx;

    psp_mac u_mac (
        .clk  (clk),
        .a    (mac_a),
        .b    (mac_b),
        .prod (prod)
    );

    assign pop_idx  = IW'(free_top_reg - CW'(1));
    assign fs_ra    = pop_idx;
    assign life_dec = (q_life > dt_reg) ? q_life - dt_reg : 16'd0;

    always_ff @(posedge clk)
    begin
        fs_q <= free_mem[fs_ra];
        if (fs_we)
            free_mem[IW'(free_top_reg)] <= slot_reg;
    end

    always_ff @(posedge clk)
    begin
        al_q <= alist_mem[al_ra];
        if (al_we)
            alist_mem[al_wa] <= al_wd;
    end

    always_ff @(posedge clk)
    begin
        q_px   <= spx_mem[slot_reg];
        q_py   <= spy_mem[slot_reg];
        q_vx   <= svx_mem[slot_reg];
        q_vy   <= svy_mem[slot_reg];
        q_life <= slife_mem[slot_reg];
        q_lmax <= slmax_mem[slot_reg];
        q_size <= ssize_mem[slot_reg];
        q_rgba <= srgba_mem[slot_reg];
        if (st_we)
        begin
            spx_mem[st_wa]   <= st_px;
            spy_mem[st_wa]   <= st_py;
            svx_mem[st_wa]   <= st_vx;
            svy_mem[st_wa]   <= st_vy;
            slife_mem[st_wa] <= st_life;
        end
        if (st_we && state_reg == S_POP)
        begin
            slmax_mem[st_wa] <= life_in_reg;
            ssize_mem[st_wa] <= size_in_reg;
            srgba_mem[st_wa] <= rgba_in_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            px_in_reg   <= pos_x;
            py_in_reg   <= pos_y;
            vx_in_reg   <= vel_x;
            vy_in_reg   <= vel_y;
            size_in_reg <= dot_size;
            rgba_in_reg <= rgba;
            life_in_reg <= life_init;
            dt_reg      <= step_time;
        end
        npx_reg     <= npx_next;
        npy_reg     <= npy_next;
        nvx_reg     <= nvx_next;
        ok_reg      <= ok_next;
        slot_id_reg <= slot_id_next;
        rpx_reg     <= rpx_next;
        rpy_reg     <= rpy_next;
        rsize_reg   <= rsize_next;
        rrgba_reg   <= rrgba_next;
        rlife_reg   <= rlife_next;
        rlmax_reg   <= rlmax_next;
        slot_reg    <= slot_next;
        idx_reg     <= idx_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            free_top_reg <= CW'(SLOT_COUNT);
            lw_reg       <= CW'(SLOT_COUNT);
            total_reg    <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            free_top_reg <= free_top_next;
            lw_reg       <= lw_next;
            total_reg    <= total_next;
            done_reg     <= done_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        free_top_next = free_top_reg;
        lw_next       = lw_reg;
        total_next    = total_reg;
        idx_next      = idx_reg;
        slot_next     = slot_reg;
        npx_next      = npx_reg;
        npy_next      = npy_reg;
        nvx_next      = nvx_reg;
        done_next     = 1'b0;
        ok_next       = ok_reg;
        slot_id_next  = slot_id_reg;
        rpx_next      = rpx_reg;
        rpy_next      = rpy_reg;
        rsize_next    = rsize_reg;
        rrgba_next    = rrgba_reg;
        rlife_next    = rlife_reg;
        rlmax_next    = rlmax_reg;
        fs_we         = 1'b0;
        al_ra         = IW'(idx_reg);
        al_we         = 1'b0;
        al_wa         = IW'(idx_reg);
        al_wd         = al_q;
        st_we         = 1'b0;
        st_wa         = slot_reg;
        st_px         = npx_reg;
        st_py         = npy_reg;
        st_vx         = nvx_reg;
        st_vy         = damp(prod);
        st_life       = life_dec;
        mac_a         = q_vx;
        mac_b         = 17'(dt_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ok_next      = 1'b0;
                    slot_id_next = '0;
                    rpx_next     = '0;
                    rpy_next     = '0;
                    rsize_next   = '0;
                    rrgba_next   = '0;
                    rlife_next   = '0;
                    rlmax_next   = '0;
                    al_ra        = IW'(list_pos);
                    case (req_t'(req_type))
                        REQ_SPAWN:
                        begin
                            if (free_top_reg != '0)
                                state_next = S_POP;
                            else
                                done_next = 1'b1;
                        end
                        REQ_TICK:
                        begin
                            idx_next   = '0;
                            state_next = T_LIST;
                        end
                        REQ_READ:
                        begin
                            if (32'(list_pos) < 32'(total_reg))
                                state_next = R_A;
                            else
                                done_next = 1'b1;
                        end
                        default:
                            done_next = 1'b1;
                    endcase
                end
            end
            S_POP:
            begin
                slot_next = (CW'(pop_idx) < lw_reg) ? pop_idx : fs_q;
                if (CW'(pop_idx) < lw_reg)
                    lw_next = CW'(pop_idx);
                st_we         = 1'b1;
                st_wa         = slot_next;
                st_px         = px_in_reg;
                st_py         = py_in_reg;
                st_vx         = vx_in_reg;
                st_vy         = vy_in_reg;
                st_life       = life_in_reg;
                al_we         = 1'b1;
                al_wa         = IW'(total_reg);
                al_wd         = slot_next;
                free_top_next = free_top_reg - CW'(1);
                total_next    = total_reg + CW'(1);
                ok_next       = 1'b1;
                slot_id_next  = 6'(slot_next);
                done_next     = 1'b1;
                state_next    = S_IDLE;
            end
            T_LIST:
            begin
                if (idx_reg < total_reg)
                    state_next = T_LA;
                else
                begin
                    ok_next    = 1'b1;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            T_LA:
            begin
                slot_next  = al_q;
                state_next = T_SLOT;
            end
            T_SLOT:
                state_next = T_M0;
            T_M0:
                state_next = T_M1;
            T_M1:
            begin
                npx_next   = pos_step(q_px, prod);
                mac_a      = q_vy;
                state_next = T_M2;
            end
            T_M2:
            begin
                npy_next   = pos_step(q_py, prod);
                mac_b      = DAMP_Q16;
                state_next = T_M3;
            end
            T_M3:
            begin
                nvx_next   = damp(prod);
                mac_a      = q_vy;
                mac_b      = DAMP_Q16;
                state_next = T_WR;
            end
            T_WR:
            begin
                st_we = 1'b1;
                if (life_dec == 16'd0)
                    state_next = T_RM1;
                else
                begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = T_LIST;
                end
            end
            T_RM1:
            begin
                al_ra      = IW'(total_reg - CW'(1));
                state_next = T_RM2;
            end
            T_RM2:
            begin
                // swap-remove: last entry moves into this position, revisit it
                al_we         = 1'b1;
                fs_we         = 1'b1;
                total_next    = total_reg - CW'(1);
                free_top_next = free_top_reg + CW'(1);
                state_next    = T_LIST;
            end
            R_A:
            begin
                slot_next  = al_q;
                state_next = R_S;
            end
            R_S:
                state_next = R_O;
            R_O:
            begin
                ok_next      = 1'b1;
                slot_id_next = 6'(slot_reg);
                rpx_next     = q_px;
                rpy_next     = q_py;
                rsize_next   = q_size;
                rrgba_next   = q_rgba;
                rlife_next   = q_life;
                rlmax_next   = q_lmax;
                done_next    = 1'b1;
                state_next   = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign ok         = ok_reg;
    assign slot_id    = slot_id_reg;
    assign live_count = 7'(total_reg);
    assign out_pos_x  = rpx_reg;
    assign out_pos_y  = rpy_reg;
    assign out_size   = rsize_reg;
    assign out_rgba   = rrgba_reg;
    assign life_left  = rlife_reg;
    assign life_total = rlmax_reg;

    a_idle_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE && state_next == S_IDLE) |=> done_reg)
        else $error("request finished without a result strobe");

    a_conserve: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |->
            ((CW+1)'(free_top_reg) + (CW+1)'(total_reg) == (CW+1)'(SLOT_COUNT)))
        else $error("free and active counts disagree");

    a_low_water: assert property (@(posedge clk) disable iff (!rst_n)
        lw_reg <= free_top_reg)
        else $error("free stack low-water mark above top");

    a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= CW'(SLOT_COUNT))
        else $error("active count out of range");

endmodule

>>> tb/tb_particle_slot_pool.sv
`timescale 1ns / 100ps

module tb_particle_slot_pool;
    import psp_pkg::*;

    localparam int NSLOT = 64;
    localparam int IDLE_LIMIT = 20000;

    typedef struct {
        logic        ok;
        logic [5:0]  slot_id;
        logic [6:0]  live_count;
        logic [23:0] pos_x;
        logic [23:0] pos_y;
        logic [7:0]  size;
        logic [31:0] rgba;
        logic [15:0] life_left;
        logic [15:0] life_total;
    } pool_result_t;

    logic clk, rst_n, start, busy, done;
    logic [1:0] req_type;
    logic signed [23:0] pos_x, pos_y, vel_x, vel_y;
    logic [7:0] dot_size;
    logic [31:0] rgba;
    logic [15:0] life_init, step_time;
    logic [5:0] list_pos;
    logic ok;
    logic [5:0] slot_id;
    logic [6:0] live_count;
    logic signed [23:0] out_pos_x, out_pos_y;
    logic [7:0] out_size;
    logic [31:0] out_rgba;
    logic [15:0] life_left, life_total;

    // pool shadow
    int unsigned free_stk[NSLOT];
    int unsigned free_top;
    int unsigned act_list[NSLOT];
    int unsigned act_total;
    longint sh_px[NSLOT], sh_py[NSLOT], sh_vx[NSLOT], sh_vy[NSLOT];
    int unsigned sh_life[NSLOT], sh_lmax[NSLOT], sh_size[NSLOT];
    logic [31:0] sh_rgba[NSLOT];

    pool_result_t pending_results[$];
    int errors = 0;
    int n_spawn = 0, n_tick = 0, n_read = 0, n_none = 0, n_full = 0, n_freed = 0;
    int idle_cycles = 0;

    particle_slot_pool i_dut (.*);

    initial begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    function automatic longint floor_div4096(longint v);
        if (v >= 0)
            return v >>> 12;
        return -((-v + 4095) >>> 12);
    endfunction

    function automatic longint damp_q16(longint v);
        if (v >= 0)
            return (v * 64225) >>> 16;
        return -((-v * 64225) >>> 16);
    endfunction

    function automatic longint clamp24(longint v);
        if (v > 8388607)
            return 8388607;
        if (v < -8388608)
            return -8388608;
        return v;
    endfunction

    function automatic void pool_reset();
        for (int i = 0; i < NSLOT; i++)
            free_stk[i] = i;
        free_top = NSLOT;
        act_total = 0;
    endfunction

    function automatic pool_result_t pool_predict(req_t rq, logic signed [23:0] px,
            logic signed [23:0] py, logic signed [23:0] vx, logic signed [23:0] vy,
            logic [7:0] sz, logic [31:0] col, logic [15:0] life, logic [15:0] dt,
            logic [5:0] lp);
        pool_result_t r;
        int unsigned s, i;
        r = '{default: '0};
        case (rq)
            REQ_SPAWN: begin
                if (free_top > 0) begin
                    s = free_stk[free_top - 1];
                    free_top--;
                    sh_px[s] = longint'(px); sh_py[s] = longint'(py);
                    sh_vx[s] = longint'(vx); sh_vy[s] = longint'(vy);
                    sh_size[s] = 32'(sz); sh_rgba[s] = col;
                    sh_life[s] = 32'(life); sh_lmax[s] = 32'(life);
                    act_list[act_total] = s;
                    act_total++;
                    r.ok = 1;
                    r.slot_id = s[5:0];
                end else begin
                    n_full++;
                end
            end
            REQ_TICK: begin
                i = 0;
                while (i < act_total) begin
                    s = act_list[i];
                    sh_px[s] = clamp24(sh_px[s] + floor_div4096(sh_vx[s] * dt + 2048));
                    sh_py[s] = clamp24(sh_py[s] + floor_div4096(sh_vy[s] * dt + 2048));
                    sh_vx[s] = damp_q16(sh_vx[s]);
                    sh_vy[s] = damp_q16(sh_vy[s]);
                    sh_life[s] = (sh_life[s] > dt) ? sh_life[s] - dt : 0;
                    if (sh_life[s] == 0) begin
                        act_list[i] = act_list[act_total - 1];
                        act_total--;
                        free_stk[free_top] = s;
                        free_top++;
                        n_freed++;
                    end else begin
                        i++;
                    end
                end
                r.ok = 1;
            end
            REQ_READ: begin
                if (lp < act_total) begin
                    s = act_list[lp];
                    r.ok = 1;
                    r.slot_id = s[5:0];
                    r.pos_x = sh_px[s][23:0];
                    r.pos_y = sh_py[s][23:0];
                    r.size = sh_size[s][7:0];
                    r.rgba = sh_rgba[s];
                    r.life_left = sh_life[s][15:0];
                    r.life_total = sh_lmax[s][15:0];
                end
            end
            default: ;
        endcase
        r.live_count = act_total[6:0];
        return r;
    endfunction

    always @(posedge clk) begin
        pool_result_t e;
        if (done) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual ok=%0b slot=%0d",
                         $time, ok, slot_id);
                errors++;
            end else begin
                e = pending_results.pop_front();
                if ({ok, slot_id, live_count, out_pos_x, out_pos_y, out_size, out_rgba,
                     life_left, life_total} !==
                    {e.ok, e.slot_id, e.live_count, e.pos_x, e.pos_y, e.size, e.rgba,
                     e.life_left, e.life_total}) begin
                    $display("%0t: mismatch expected ok=%0b slot=%0d live=%0d x=%h y=%h sz=%h col=%h life=%h/%h",
                             $time, e.ok, e.slot_id, e.live_count, e.pos_x, e.pos_y,
                             e.size, e.rgba, e.life_left, e.life_total);
                    $display("%0t:          actual   ok=%0b slot=%0d live=%0d x=%h y=%h sz=%h col=%h life=%h/%h",
                             $time, ok, slot_id, live_count, out_pos_x, out_pos_y,
                             out_size, out_rgba, life_left, life_total);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // start stays high after an accept so that a zero gap issues back to back;
    // it is dropped before a gap and by drain
    task automatic send_request(req_t rq, logic signed [23:0] px, logic signed [23:0] py,
            logic signed [23:0] vx, logic signed [23:0] vy, logic [7:0] sz,
            logic [31:0] col, logic [15:0] life, logic [15:0] dt, logic [5:0] lp);
        int gap;
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 10);
        if (gap != 0) begin
            start <= 0;
            repeat (gap) @(posedge clk);
        end
        start <= 1;
        req_type <= rq;
        pos_x <= px; pos_y <= py; vel_x <= vx; vel_y <= vy;
        dot_size <= sz; rgba <= col; life_init <= life; step_time <= dt; list_pos <= lp;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_results.push_back(pool_predict(rq, px, py, vx, vy, sz, col, life, dt, lp));
        case (rq)
            REQ_SPAWN: n_spawn++;
            REQ_TICK:  n_tick++;
            REQ_READ:  n_read++;
            default:   n_none++;
        endcase
    endtask

    task automatic spawn(logic signed [23:0] px, logic signed [23:0] py,
            logic signed [23:0] vx, logic signed [23:0] vy, logic [15:0] life);
        send_request(REQ_SPAWN, px, py, vx, vy, 8'($urandom()), $urandom(), life,
                     16'($urandom()), 6'($urandom()));
    endtask

    task automatic tick(logic [15:0] dt);
        send_request(REQ_TICK, 24'($urandom()), 24'($urandom()), 24'($urandom()),
                     24'($urandom()), 8'($urandom()), $urandom(), 16'($urandom()), dt,
                     6'($urandom()));
    endtask

    task automatic read_at(logic [5:0] lp);
        send_request(REQ_READ, 24'($urandom()), 24'($urandom()), 24'($urandom()),
                     24'($urandom()), 8'($urandom()), $urandom(), 16'($urandom()),
                     16'($urandom()), lp);
    endtask

    task automatic drain();
        start <= 0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic test_directed();
        spawn(24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 24'sh800000, 16'hFFFF);
        spawn(24'sh800000, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 16'h0000);
        spawn(24'sd0, 24'sd0, 24'sh000100, -24'sh000100, 16'h1000);
        read_at(0);
        read_at(2);
        read_at(3);
        read_at(6'h3F);
        send_request(REQ_NONE, '1, '1, '1, '1, '1, '1, '1, '1, '1);
        tick(16'h0000);
        read_at(0);
        read_at(1);
        tick(16'h0800);
        read_at(1);
        tick(16'hFFFF);
        read_at(0);
        tick(16'h0001);
        drain();
    endtask

    task automatic test_pool_full();
        for (int i = 0; i < NSLOT + 3; i++)
            spawn(24'($urandom()), 24'($urandom()), 24'($urandom()), 24'($urandom()),
                  16'($urandom_range(1, 16'hFFFF)));
        read_at(6'd63);
        read_at(6'($urandom()));
        tick(16'hFFFF);
        tick(16'hFFFF);
        drain();
    endtask

    task automatic test_random(int count);
        int sel;
        for (int i = 0; i < count; i++) begin
            sel = $urandom_range(0, 99);
            if (sel < 45)
                spawn(24'($urandom()), 24'($urandom()),
                      24'(($urandom_range(0, 3) == 0) ?
                          $urandom() : $urandom_range(0, 8192) - 4096),
                      24'(($urandom_range(0, 3) == 0) ?
                          $urandom() : $urandom_range(0, 8192) - 4096),
                      16'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 1) : $urandom()));
            else if (sel < 60)
                tick(16'(($urandom_range(0, 3) == 0) ?
                         $urandom() : $urandom_range(0, 16'h1000)));
            else if (sel < 97)
                read_at(6'(($urandom_range(0, 4) == 0) ?
                           $urandom() : $urandom_range(0, act_total)));
            else
                send_request(REQ_NONE, 24'($urandom()), 24'($urandom()), 24'($urandom()),
                             24'($urandom()), 8'($urandom()), $urandom(),
                             16'($urandom()), 16'($urandom()), 6'($urandom()));
            if (i == count / 2)
                drain();
        end
        drain();
    endtask

    initial begin
        rst_n = 0;
        start = 0;
        req_type = REQ_SPAWN;
        {pos_x, pos_y, vel_x, vel_y} = '0;
        dot_size = 0; rgba = 0; life_init = 0; step_time = 0; list_pos = 0;
        pool_reset();
        repeat (8) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        test_directed();
        test_pool_full();
        test_random(450);
        $display("Requests: %0d spawn, %0d tick, %0d read, %0d unused code", n_spawn, n_tick,
                 n_read, n_none);
        $display("Pool-full spawns: %0d, particles expired: %0d", n_full, n_freed);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> sim.f
sv/psp_pkg.sv
sv/psp_mac.sv
sv/particle_slot_pool.sv
tb/tb_particle_slot_pool.sv
